// ----- hw/rtl/vlrs_pkg.sv -----
// Shared types and constants for the voltage-level residency statistics block.
`default_nettype none
package vlrs_pkg;

   localparam int LEVELS     = 4;
   localparam int COMPONENTS = 4;

   localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LT_DEPTH = 1 << LVL_W;
   localparam int TR_AW    = 2 * LVL_W;
   localparam int TR_DEPTH = 1 << TR_AW;
   localparam int CMP_W    = $clog2(COMPONENTS);

   localparam int TIME_W = 48;
   localparam int CNT_W  = 32;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

   localparam int FIFO_DEPTH = 3;
   localparam int FIFO_AW    = 2;

   typedef enum logic [2:0] {
      MODE_EVENT    = 3'd0,
      MODE_RAIL     = 3'd1,
      MODE_START    = 3'd2,
      MODE_STOP     = 3'd3,
      MODE_RD_TIME  = 3'd4,
      MODE_RD_TRANS = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ALREADY    = 3'd1,
      ST_RUNNING    = 3'd2,
      ST_NO_STATS   = 3'd3,
      ST_RAIL_IGNORED = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]        mode;
      logic [TIME_W-1:0] now_us;
      logic [2:0]        power_mode;
      logic [2:0]        rail;
      logic [1:0]        new_level;
      logic [1:0]        from_level;
      logic [1:0]        to_level;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [TIME_W-1:0] value;
      logic [TIME_W-1:0] total;
      logic [1:0]        current_level;
   } rsp_type;

endpackage
`default_nettype wire

// ----- hw/rtl/vlrs_rsp_fifo.sv -----
// Three-entry response queue that decouples the update pipe from the receiver.
`default_nettype none
module vlrs_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push_valid,
   input  wire vlrs_pkg::rsp_type             push_data,
   input  wire logic                          pop_ready,
   output logic                               pop_valid,
   output vlrs_pkg::rsp_type                  pop_data,
   output logic [vlrs_pkg::FIFO_AW-1:0]       count
);

   localparam logic [vlrs_pkg::FIFO_AW-1:0] LAST = vlrs_pkg::FIFO_AW'(vlrs_pkg::FIFO_DEPTH - 1);

   vlrs_pkg::rsp_type                 entry_ff [vlrs_pkg::FIFO_DEPTH];
   logic [vlrs_pkg::FIFO_AW-1:0]      head_ff, head_in;
   logic [vlrs_pkg::FIFO_AW-1:0]      tail_ff, tail_in;
   logic [vlrs_pkg::FIFO_AW-1:0]      count_ff, count_in;
   logic                              pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[head_ff];
   assign count     = count_ff;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push_valid) begin
         tail_in = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/voltage_level_residency_stats_core.sv -----
// Top level of the voltage-level residency and transition statistics block.
//
// Usage
//   req_*  : one request per accepted cycle (req_valid && req_ready). The mode
//            field selects power-mode event, rail level change, start, stop,
//            level-time read or transition-count read.
//   rsp_*  : exactly one response per request, in request order.
// Pipeline: stage 0 issues the memory reads, stage 1 does the
//           read-modify-write and pushes into the response queue, which
//           offers each response from its registered entries.
// Throughput: one request per cycle while req_ready is high. The level-time
//           and transition memories are written once per cycle from stage 1;
//           a request reading its predecessor's entry uses a bypass register.
// Stall   : the three-entry response queue absorbs the pipe; req_ready drops
//           once queued plus in-flight responses reach three, so nothing is
//           lost while rsp_ready is low.
// Reset   : synchronous, active high. All control state clears at once; the
//           counter memories carry per-entry valid flags, so no clearing pass
//           is needed, and start clears the flags at once too.
`default_nettype none
module voltage_level_residency_stats_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire vlrs_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output vlrs_pkg::rsp_type       rsp_data
);

   localparam int LVL_W  = vlrs_pkg::LVL_W;
   localparam int TR_AW  = vlrs_pkg::TR_AW;
   localparam int TIME_W = vlrs_pkg::TIME_W;
   localparam int CNT_W  = vlrs_pkg::CNT_W;
   localparam int CMP_W  = vlrs_pkg::CMP_W;
   localparam int FIFO_CNT_W = vlrs_pkg::FIFO_AW;

   typedef enum logic [1:0] {
      VSEL_NONE = 2'd0,
      VSEL_LT   = 2'd1,
      VSEL_TR   = 2'd2
   } vsel_type;

   // stage-1 payload: what the read-modify-write and the response need
   typedef struct packed {
      logic                  lt_we;
      logic                  tr_we;
      logic [LVL_W-1:0]      lt_addr;
      logic [TR_AW-1:0]      tr_addr;
      logic [TIME_W-1:0]     dt;
      vlrs_pkg::status_type  status;
      vsel_type              vsel;
      logic                  in_range;
      logic [TIME_W-1:0]     tt_snap;
      logic [1:0]            current_level;
   } s1_type;

   // ---------------- control state ----------------
   logic [1:0]        comp_level_ff [vlrs_pkg::COMPONENTS];
   logic              running_ff, running_in;
   logic [1:0]        timed_ff, timed_in;
   logic [TIME_W-1:0] istart_ff, istart_in;
   logic [TIME_W-1:0] sstart_ff, sstart_in;
   logic [TIME_W-1:0] ttime_ff, ttime_in;
   logic [CNT_W-1:0]  ttrans_ff, ttrans_in;

   logic              s1_valid_ff;
   s1_type            s1_ff, s1_in;

   // ---------------- memories ----------------
   logic [TIME_W-1:0]             lt_mem [vlrs_pkg::LT_DEPTH];
   logic [CNT_W-1:0]              tr_mem [vlrs_pkg::TR_DEPTH];
   logic [vlrs_pkg::LT_DEPTH-1:0] lt_vld_ff;
   logic [vlrs_pkg::TR_DEPTH-1:0] tr_vld_ff;
   logic [TIME_W-1:0]             lt_rd_ff;
   logic [CNT_W-1:0]              tr_rd_ff;
   logic                          lt_rd_vld_ff, tr_rd_vld_ff;

   // bypass of the write made at the edge where the stage-1 read was taken
   logic                          lt_fwd_vld_ff, tr_fwd_vld_ff;
   logic [LVL_W-1:0]              lt_fwd_addr_ff;
   logic [TR_AW-1:0]              tr_fwd_addr_ff;
   logic [TIME_W-1:0]             lt_fwd_data_ff;
   logic [CNT_W-1:0]              tr_fwd_data_ff;

   // ---------------- stage 0 signals ----------------
   logic                   accept;
   logic                   clear;
   logic                   comp_we;
   logic [CMP_W-1:0]       comp_sel;
   logic [1:0]             nl_clamp;
   logic [1:0]             tlvl;
   logic                   time_req;
   logic                   rail_ok;
   logic                   from_ok, to_ok;
   logic [FIFO_CNT_W-1:0]  fifo_count;

   // ---------------- stage 1 signals ----------------
   logic [TIME_W-1:0] lt_old, lt_new;
   logic [TIME_W:0]   lt_sum;
   logic [CNT_W-1:0]  tr_old, tr_new;
   logic              tr_sat;
   logic              lt_wr, tr_wr;
   vlrs_pkg::rsp_type s1_rsp;

   assign accept  = req_valid && req_ready;
   assign req_ready = ({1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid_ff})
                      < (FIFO_CNT_W + 1)'(vlrs_pkg::FIFO_DEPTH);

   assign rail_ok  = {1'b0, req_data.rail} < 4'(vlrs_pkg::COMPONENTS);
   assign from_ok  = {3'b000, req_data.from_level} < 5'(vlrs_pkg::LEVELS);
   assign to_ok    = {3'b000, req_data.to_level} < 5'(vlrs_pkg::LEVELS);
   assign nl_clamp = ({3'b000, req_data.new_level} < 5'(vlrs_pkg::LEVELS))
                     ? req_data.new_level : 2'(vlrs_pkg::LEVELS - 1);
   // power modes 1..3 pick their own component, everything else is active
   assign comp_sel = (req_data.power_mode >= 3'd1 && req_data.power_mode <= 3'd3)
                     ? CMP_W'(req_data.power_mode) : '0;

   always_comb begin
      running_in = running_ff;
      timed_in   = timed_ff;
      istart_in  = istart_ff;
      sstart_in  = sstart_ff;
      ttime_in   = ttime_ff;
      clear      = 1'b0;
      comp_we    = 1'b0;
      time_req   = 1'b0;
      tlvl       = comp_level_ff[comp_sel];

      s1_in.lt_we         = 1'b0;
      s1_in.tr_we         = 1'b0;
      s1_in.lt_addr       = LVL_W'(timed_ff);
      s1_in.tr_addr       = {LVL_W'(timed_ff), LVL_W'(tlvl)};
      s1_in.dt            = req_data.now_us - istart_ff;
      s1_in.status        = vlrs_pkg::ST_OK;
      s1_in.vsel          = VSEL_NONE;
      s1_in.in_range      = 1'b0;
      s1_in.tt_snap       = ttime_ff;
      s1_in.current_level = timed_ff;

      if (accept) begin
         unique case (vlrs_pkg::mode_type'(req_data.mode))
            vlrs_pkg::MODE_EVENT: begin
               time_req = running_ff;
            end
            vlrs_pkg::MODE_RAIL: begin
               if (!rail_ok) begin
                  s1_in.status = vlrs_pkg::ST_RAIL_IGNORED;
               end else begin
                  comp_we = 1'b1;
                  // only the active component re-times the current level
                  if (req_data.rail == 3'd0) begin
                     tlvl     = nl_clamp;
                     time_req = running_ff;
                  end
               end
            end
            vlrs_pkg::MODE_START: begin
               if (running_ff) begin
                  s1_in.status = vlrs_pkg::ST_ALREADY;
               end else begin
                  running_in = 1'b1;
                  clear      = 1'b1;
                  istart_in  = req_data.now_us;
                  sstart_in  = req_data.now_us;
                  timed_in   = comp_level_ff[0];
                  ttime_in   = vlrs_pkg::TIME_MAX;
               end
            end
            vlrs_pkg::MODE_STOP: begin
               if (!running_ff) begin
                  s1_in.status = vlrs_pkg::ST_ALREADY;
               end else begin
                  running_in  = 1'b0;
                  s1_in.lt_we = 1'b1;
                  istart_in   = req_data.now_us;
                  ttime_in    = req_data.now_us - sstart_ff;
               end
            end
            vlrs_pkg::MODE_RD_TIME, vlrs_pkg::MODE_RD_TRANS: begin
               s1_in.lt_addr = LVL_W'(req_data.from_level);
               s1_in.tr_addr = {LVL_W'(req_data.from_level), LVL_W'(req_data.to_level)};
               if (ttime_ff == '0) begin
                  s1_in.status = vlrs_pkg::ST_NO_STATS;
               end else if (running_ff) begin
                  s1_in.status = vlrs_pkg::ST_RUNNING;
               end else if (req_data.mode == vlrs_pkg::MODE_RD_TIME) begin
                  s1_in.vsel     = VSEL_LT;
                  s1_in.in_range = from_ok;
               end else begin
                  s1_in.vsel     = VSEL_TR;
                  s1_in.in_range = from_ok && to_ok;
               end
            end
            default: begin
            end
         endcase

         if (time_req) begin
            s1_in.tr_addr = {LVL_W'(timed_ff), LVL_W'(tlvl)};
         end
         if (time_req && (tlvl != timed_ff)) begin
            s1_in.lt_we = 1'b1;
            s1_in.tr_we = 1'b1;
            istart_in   = req_data.now_us;
            timed_in    = tlvl;
         end
      end
      s1_in.current_level = timed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         timed_ff    <= '0;
         istart_ff   <= '0;
         sstart_ff   <= '0;
         ttime_ff    <= '0;
         s1_valid_ff <= 1'b0;
         for (int i = 0; i < vlrs_pkg::COMPONENTS; i++) begin
            comp_level_ff[i] <= '0;
         end
      end else begin
         running_ff  <= running_in;
         timed_ff    <= timed_in;
         istart_ff   <= istart_in;
         sstart_ff   <= sstart_in;
         ttime_ff    <= ttime_in;
         s1_valid_ff <= accept;
         if (comp_we) begin
            comp_level_ff[req_data.rail[CMP_W-1:0]] <= nl_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- stage 1: read-modify-write ----------------
   always_comb begin
      if (lt_fwd_vld_ff && (lt_fwd_addr_ff == s1_ff.lt_addr)) begin
         lt_old = lt_fwd_data_ff;
      end else begin
         lt_old = lt_rd_vld_ff ? lt_rd_ff : '0;
      end
      if (tr_fwd_vld_ff && (tr_fwd_addr_ff == s1_ff.tr_addr)) begin
         tr_old = tr_fwd_data_ff;
      end else begin
         tr_old = tr_rd_vld_ff ? tr_rd_ff : '0;
      end
   end

   assign lt_sum = {1'b0, lt_old} + {1'b0, s1_ff.dt};
   assign lt_new = lt_sum[TIME_W] ? vlrs_pkg::TIME_MAX : lt_sum[TIME_W-1:0];
   assign tr_sat = (tr_old == vlrs_pkg::CNT_MAX);
   assign tr_new = tr_sat ? tr_old : tr_old + 1'b1;
   assign lt_wr  = s1_valid_ff && s1_ff.lt_we;
   assign tr_wr  = s1_valid_ff && s1_ff.tr_we;

   // running sum of the saturated pair counts; start wins over an increment
   always_comb begin
      ttrans_in = ttrans_ff;
      if (clear) begin
         ttrans_in = '0;
      end else if (tr_wr && !tr_sat && (ttrans_ff != vlrs_pkg::CNT_MAX)) begin
         ttrans_in = ttrans_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttrans_ff     <= '0;
         lt_vld_ff     <= '0;
         tr_vld_ff     <= '0;
         lt_fwd_vld_ff <= 1'b0;
         tr_fwd_vld_ff <= 1'b0;
      end else begin
         ttrans_ff     <= ttrans_in;
         lt_fwd_vld_ff <= lt_wr && !clear;
         tr_fwd_vld_ff <= tr_wr && !clear;
         if (clear) begin
            lt_vld_ff <= '0;
            tr_vld_ff <= '0;
         end else begin
            if (lt_wr) begin
               lt_vld_ff[s1_ff.lt_addr] <= 1'b1;
            end
            if (tr_wr) begin
               tr_vld_ff[s1_ff.tr_addr] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lt_fwd_addr_ff <= s1_ff.lt_addr;
      lt_fwd_data_ff <= lt_new;
      tr_fwd_addr_ff <= s1_ff.tr_addr;
      tr_fwd_data_ff <= tr_new;
      if (accept) begin
         lt_rd_ff     <= lt_mem[s1_in.lt_addr];
         tr_rd_ff     <= tr_mem[s1_in.tr_addr];
         lt_rd_vld_ff <= lt_vld_ff[s1_in.lt_addr];
         tr_rd_vld_ff <= tr_vld_ff[s1_in.tr_addr];
      end
      if (lt_wr) begin
         lt_mem[s1_ff.lt_addr] <= lt_new;
      end
      if (tr_wr) begin
         tr_mem[s1_ff.tr_addr] <= tr_new;
      end
   end

   // response assembly
   always_comb begin
      s1_rsp.status        = s1_ff.status;
      s1_rsp.current_level = s1_ff.current_level;
      s1_rsp.value         = '0;
      s1_rsp.total         = '0;
      case (s1_ff.vsel)
         VSEL_LT: begin
            s1_rsp.value = s1_ff.in_range ? lt_old : '0;
            s1_rsp.total = s1_ff.tt_snap;
         end
         VSEL_TR: begin
            s1_rsp.value = s1_ff.in_range ? TIME_W'(tr_old) : '0;
            s1_rsp.total = TIME_W'(ttrans_ff);
         end
         default: begin
         end
      endcase
   end

   vlrs_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (s1_valid_ff),
      .push_data  (s1_rsp),
      .pop_ready  (rsp_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (rsp_data),
      .count      (fifo_count)
   );

   // ---------------- assertions ----------------
   a_ttime_marks_run: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (ttime_ff == vlrs_pkg::TIME_MAX))
      else $error("total time not all ones during a run");

   a_no_overcommit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid_ff})
         <= (FIFO_CNT_W + 1)'(vlrs_pkg::FIFO_DEPTH))
      else $error("response queue overcommitted");

   a_stage1_from_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request did not enter stage 1");

   a_trans_only_running: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.tr_we) |-> running_ff)
      else $error("transition counted outside a run");

endmodule
`default_nettype wire
